// ===== rtl/ll1pe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll1pe_pkg
// Shared types, codes and defaults of the LL(1) parse engine.
// ----------------------------------------------------------------------------
package ll1pe_pkg;

   localparam int TABLE_DEPTH_DEF   = 256;
   localparam int STACK_DEPTH_DEF   = 32;
   localparam int NUM_TERMINALS_DEF = 64;

   localparam int INDEX_W  = 8;
   localparam int ACTION_W = 6;
   localparam int TOKEN_W  = 6;
   localparam int FLAGS_W  = 5;
   localparam int MASK_W   = 64;
   localparam int VISIT_W  = 6;
   localparam int LINK_W   = FLAGS_W + 1 + INDEX_W + ACTION_W;

   localparam logic [1:0] FUNC_WRITE   = 2'd0;
   localparam logic [1:0] FUNC_TOKEN   = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   localparam logic CSR_START_STATE = 1'b0;
   localparam logic CSR_STEP_LIMIT  = 1'b1;

   localparam logic [INDEX_W-1:0] START_STATE_RST = 8'd0;
   localparam logic [VISIT_W-1:0] STEP_LIMIT_RST  = 6'd63;

   localparam int FLAG_ATTR  = 0;
   localparam int FLAG_ERR   = 1;
   localparam int FLAG_END   = 2;
   localparam int FLAG_PUSH  = 3;
   localparam int FLAG_SHIFT = 4;

   typedef enum logic [2:0] {
      KIND_ACTION    = 3'd0,
      KIND_ACCEPTED  = 3'd1,
      KIND_SYNTAX    = 3'd2,
      KIND_OVERFLOW  = 3'd3,
      KIND_UNDERFLOW = 3'd4,
      KIND_LIMIT     = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      NXT_HOLD,
      NXT_FOLLOW,
      NXT_POP,
      NXT_RETURN
   } next_sel_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [INDEX_W-1:0]  entry_addr;
      logic [FLAGS_W-1:0]  entry_flags;
      logic                entry_has_next;
      logic [INDEX_W-1:0]  entry_next;
      logic [MASK_W-1:0]   entry_terminals;
      logic [ACTION_W-1:0] entry_action;
      logic [TOKEN_W-1:0]  token;
   } req_word_type;

   typedef struct packed {
      kind_type            kind;
      logic [ACTION_W-1:0] action_id;
      logic [INDEX_W-1:0]  state_index;
      logic                last;
   } rsp_word_type;

   typedef struct packed {
      logic         load_entry;
      logic         restart;
      logic         start;
      logic         visit;
      logic         post;
      kind_type     post_kind;
      logic         alt;
      next_sel_type next_sel;
      logic         push;
      logic         pop_load;
      logic         commit;
      logic         flush;
   } cmd_type;

   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic               has_next;
      logic               accepts;
      logic               step_hit;
      logic               stack_full;
      logic               stack_empty;
      logic               pend_valid;
      logic               slot_free;
   } status_type;

endpackage

// ===== rtl/ll1pe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll1pe_ctrl
// Sequencer of the parse engine: accepts words, walks table entries and
// orders result delivery through the datapath.
// ----------------------------------------------------------------------------
module ll1pe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_func,
   output logic                 req_stall,
   input  ll1pe_pkg::status_type status,
   output ll1pe_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VISIT,
      ST_READ,
      ST_POP,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      attr_done_ff, attr_done_in;
   logic      blocked;
   logic      is_attr;

   assign blocked   = status.pend_valid && !status.slot_free;
   assign is_attr   = status.flags[ll1pe_pkg::FLAG_ATTR];
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.post_kind = ll1pe_pkg::KIND_ACTION;
      cmd.next_sel = ll1pe_pkg::NXT_HOLD;
      state_in     = state_ff;
      attr_done_in = attr_done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  ll1pe_pkg::FUNC_WRITE: begin
                     cmd.load_entry = 1'b1;
                  end
                  ll1pe_pkg::FUNC_TOKEN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_VISIT;
                  end
                  ll1pe_pkg::FUNC_RESTART: begin
                     cmd.restart = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_VISIT: begin
            if (status.step_hit) begin
               if (!blocked) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = ll1pe_pkg::KIND_LIMIT;
                  cmd.restart   = 1'b1;
                  state_in      = ST_FLUSH;
               end
            end else begin
               cmd.visit = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (is_attr && !attr_done_ff) begin
               if (!blocked) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = ll1pe_pkg::KIND_ACTION;
                  attr_done_in  = 1'b1;
               end
            end else if (!is_attr && !status.accepts) begin
               if (status.flags[ll1pe_pkg::FLAG_ERR]) begin
                  if (!blocked) begin
                     cmd.post      = 1'b1;
                     cmd.post_kind = ll1pe_pkg::KIND_SYNTAX;
                     cmd.restart   = 1'b1;
                     state_in      = ST_FLUSH;
                  end
               end else begin
                  cmd.alt  = 1'b1;
                  state_in = ST_VISIT;
               end
            end else if (status.flags[ll1pe_pkg::FLAG_END]) begin
               if (!blocked) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = ll1pe_pkg::KIND_ACCEPTED;
                  cmd.restart   = 1'b1;
                  attr_done_in  = 1'b0;
                  state_in      = ST_FLUSH;
               end
            end else if (status.flags[ll1pe_pkg::FLAG_PUSH] && status.stack_full) begin
               if (!blocked) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = ll1pe_pkg::KIND_OVERFLOW;
                  cmd.restart   = 1'b1;
                  attr_done_in  = 1'b0;
                  state_in      = ST_FLUSH;
               end
            end else if (status.has_next || status.flags[ll1pe_pkg::FLAG_PUSH]) begin
               cmd.push     = status.has_next && status.flags[ll1pe_pkg::FLAG_PUSH];
               cmd.next_sel = status.has_next ? ll1pe_pkg::NXT_FOLLOW
                                              : ll1pe_pkg::NXT_RETURN;
               attr_done_in = 1'b0;
               if (status.flags[ll1pe_pkg::FLAG_SHIFT]) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_FLUSH;
               end else begin
                  state_in = ST_VISIT;
               end
            end else if (status.stack_empty) begin
               if (!blocked) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = ll1pe_pkg::KIND_UNDERFLOW;
                  cmd.restart   = 1'b1;
                  attr_done_in  = 1'b0;
                  state_in      = ST_FLUSH;
               end
            end else begin
               cmd.next_sel = ll1pe_pkg::NXT_POP;
               attr_done_in = 1'b0;
               state_in     = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop_load = 1'b1;
            if (status.flags[ll1pe_pkg::FLAG_SHIFT]) begin
               cmd.commit = 1'b1;
               state_in   = ST_FLUSH;
            end else begin
               state_in = ST_VISIT;
            end
         end
         ST_FLUSH: begin
            if (!blocked) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         attr_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         attr_done_ff <= attr_done_in;
      end
   end

endmodule

// ===== rtl/ll1pe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll1pe_datapath
// Parse table, return stack, walk registers, configuration registers and
// the pending and output result registers.
// ----------------------------------------------------------------------------
module ll1pe_datapath #(
   parameter int TABLE_DEPTH   = ll1pe_pkg::TABLE_DEPTH_DEF,
   parameter int STACK_DEPTH   = ll1pe_pkg::STACK_DEPTH_DEF,
   parameter int NUM_TERMINALS = ll1pe_pkg::NUM_TERMINALS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ll1pe_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ll1pe_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [7:0]             csr_data,
   input  ll1pe_pkg::cmd_type      cmd,
   output ll1pe_pkg::status_type   status
);

   localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int TW  = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
   localparam int MPW = 1 << TW;

   logic [ll1pe_pkg::LINK_W-1:0]  links_mem [TABLE_DEPTH];
   logic [NUM_TERMINALS-1:0]      masks_mem [TABLE_DEPTH];
   logic [ll1pe_pkg::INDEX_W-1:0] stack_mem [STACK_DEPTH];

   logic [ll1pe_pkg::LINK_W-1:0]  link_rd_ff;
   logic [NUM_TERMINALS-1:0]      mask_rd_ff;
   logic                          oob_ff;
   logic [ll1pe_pkg::INDEX_W-1:0] stack_rd_ff;

   logic [ll1pe_pkg::INDEX_W-1:0]  start_state_ff;
   logic [ll1pe_pkg::VISIT_W-1:0]  step_limit_ff;
   logic [ll1pe_pkg::INDEX_W-1:0]  current_ff, current_in;
   logic [ll1pe_pkg::INDEX_W-1:0]  idx_ff, idx_in;
   logic [ll1pe_pkg::VISIT_W-1:0]  visits_ff, visits_in;
   logic [ll1pe_pkg::TOKEN_W-1:0]  tok_ff;
   logic [CW-1:0]                  count_ff, count_in, count_dec;

   ll1pe_pkg::rsp_word_type pend_ff, pend_in, rsp_ff, rsp_in, post_word;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    load_rsp;

   logic [ll1pe_pkg::LINK_W-1:0]   entry_link;
   logic [NUM_TERMINALS-1:0]       entry_mask;
   logic [MPW-1:0]                 mask_pad;
   logic [ll1pe_pkg::FLAGS_W-1:0]  entry_flags;
   logic                           entry_has_next;
   logic [ll1pe_pkg::INDEX_W-1:0]  entry_next;
   logic [ll1pe_pkg::ACTION_W-1:0] entry_action;
   logic                           waddr_ok, raddr_ok;

   assign waddr_ok = int'(req_word.entry_addr) < TABLE_DEPTH;
   assign raddr_ok = int'(idx_ff) < TABLE_DEPTH;

   // table store
   always_ff @(posedge clock) begin
      if (cmd.load_entry && waddr_ok) begin
         links_mem[TAW'(req_word.entry_addr)] <= {req_word.entry_flags,
                                                  req_word.entry_has_next,
                                                  req_word.entry_next,
                                                  req_word.entry_action};
         masks_mem[TAW'(req_word.entry_addr)] <=
            NUM_TERMINALS'(req_word.entry_terminals);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.visit) begin
         link_rd_ff <= links_mem[TAW'(idx_ff)];
         mask_rd_ff <= masks_mem[TAW'(idx_ff)];
         oob_ff     <= !raddr_ok;
      end
   end

   assign entry_link     = oob_ff ? '0 : link_rd_ff;
   assign entry_mask     = oob_ff ? '0 : mask_rd_ff;
   assign mask_pad       = MPW'(entry_mask);
   assign entry_action   = entry_link[ll1pe_pkg::ACTION_W-1:0];
   assign entry_next     = entry_link[ll1pe_pkg::ACTION_W +: ll1pe_pkg::INDEX_W];
   assign entry_has_next = entry_link[ll1pe_pkg::ACTION_W + ll1pe_pkg::INDEX_W];
   assign entry_flags    = entry_link[ll1pe_pkg::LINK_W-1 -: ll1pe_pkg::FLAGS_W];

   // return stack
   assign count_dec = count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[SAW-1:0]] <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.next_sel == ll1pe_pkg::NXT_POP) begin
         stack_rd_ff <= stack_mem[count_dec[SAW-1:0]];
      end
   end

   // walk registers
   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = current_ff;
      end else if (cmd.alt) begin
         idx_in = idx_ff + 1'b1;
      end else if (cmd.pop_load) begin
         idx_in = stack_rd_ff;
      end else begin
         case (cmd.next_sel)
            ll1pe_pkg::NXT_FOLLOW: idx_in = entry_next;
            ll1pe_pkg::NXT_RETURN: idx_in = idx_ff + 1'b1;
            default:               idx_in = idx_ff;
         endcase
      end
   end

   always_comb begin
      current_in = current_ff;
      if (cmd.restart) begin
         current_in = start_state_ff;
      end else if (cmd.commit) begin
         current_in = idx_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.restart) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.next_sel == ll1pe_pkg::NXT_POP) begin
         count_in = count_dec;
      end
   end

   assign visits_in = cmd.start ? '0 : (cmd.visit ? visits_ff + 1'b1 : visits_ff);

   // result registers
   always_comb begin
      post_word.kind        = cmd.post_kind;
      post_word.action_id   = (cmd.post_kind == ll1pe_pkg::KIND_ACTION) ? entry_action : '0;
      post_word.state_index = idx_ff;
      post_word.last        = 1'b0;
   end

   assign load_rsp = (cmd.post || cmd.flush) && pend_valid_ff;

   always_comb begin
      rsp_in      = pend_ff;
      rsp_in.last = cmd.flush;
   end

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.post) begin
         pend_in       = post_word;
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= ll1pe_pkg::START_STATE_RST;
         step_limit_ff  <= ll1pe_pkg::STEP_LIMIT_RST;
         current_ff     <= ll1pe_pkg::START_STATE_RST;
         count_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               ll1pe_pkg::CSR_START_STATE: start_state_ff <= csr_data;
               ll1pe_pkg::CSR_STEP_LIMIT:  step_limit_ff  <= csr_data[ll1pe_pkg::VISIT_W-1:0];
               default: ;
            endcase
         end
         current_ff    <= current_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      visits_ff <= visits_in;
      pend_ff   <= pend_in;
      if (cmd.start) begin
         tok_ff <= req_word.token;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      status.flags       = entry_flags;
      status.has_next    = entry_has_next;
      status.accepts     = (int'(tok_ff) < NUM_TERMINALS) && mask_pad[tok_ff[TW-1:0]];
      status.step_hit    = visits_ff >= step_limit_ff;
      status.stack_full  = count_ff >= CW'(STACK_DEPTH);
      status.stack_empty = count_ff == '0;
      status.pend_valid  = pend_valid_ff;
      status.slot_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== rtl/table_driven_ll1_parse_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_ll1_parse_engine_core
// LL(1) parse-table engine: table load, token walk, action, accept and error words.
// ----------------------------------------------------------------------------
// A table write, a restart or an unused function code is handled in the idle
// state without leaving it. A token is started, then every table entry that it
// visits is read through the registered table port and then evaluated; an
// attribute entry first posts its action word, each pop of the return stack
// goes through a registered stack read, and a final step hands the last
// result to the output register. The walk waits while the output side
// stalls. Results leave through a pending register and an output register,
// so a finished word waits at the output while the next word is taken. The
// table and the return stack come up undefined and need no clearing after
// reset.
module table_driven_ll1_parse_engine_core #(
   parameter int TABLE_DEPTH   = ll1pe_pkg::TABLE_DEPTH_DEF,
   parameter int STACK_DEPTH   = ll1pe_pkg::STACK_DEPTH_DEF,
   parameter int NUM_TERMINALS = ll1pe_pkg::NUM_TERMINALS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ll1pe_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ll1pe_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [7:0]             csr_data
);

   ll1pe_pkg::cmd_type    cmd;
   ll1pe_pkg::status_type status;

   ll1pe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_word.func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ll1pe_datapath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .STACK_DEPTH   (STACK_DEPTH),
      .NUM_TERMINALS (NUM_TERMINALS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
